// File: hdl/neighbor_table_with_aging_core_macros.svh
// ----------------------------------------------------------------------------
// Neighbor table assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_TABLE_WITH_AGING_CORE_MACROS_SVH
`define NEIGHBOR_TABLE_WITH_AGING_CORE_MACROS_SVH

// Check a consequence in the same cycle as its trigger
`define NTA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define NTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/nta_pkg.sv
// ----------------------------------------------------------------------------
// Neighbor table package
// Command, status and slot state codes, the stored slot word and mask helper.
// ----------------------------------------------------------------------------
package nta_pkg;

  // Commands
  localparam logic [2:0] CMD_HEARD  = 3'd0;
  localparam logic [2:0] CMD_AGE    = 3'd1;
  localparam logic [2:0] CMD_SETBIT = 3'd2;
  localparam logic [2:0] CMD_LOOKUP = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  // Result status
  localparam logic [2:0] STS_DONE     = 3'd0;
  localparam logic [2:0] STS_ADDED    = 3'd1;
  localparam logic [2:0] STS_FULL     = 3'd2;
  localparam logic [2:0] STS_NOTFOUND = 3'd3;
  localparam logic [2:0] STS_BADIDX   = 3'd4;

  // Slot states
  localparam logic [1:0] ENT_DISC  = 2'd0;
  localparam logic [1:0] ENT_NOBIT = 2'd1;
  localparam logic [1:0] ENT_CONN  = 2'd2;

  // One slot as held in the slot memory
  typedef struct packed {
    logic [7:0]  bitn;
    logic [31:0] contact;
    logic [31:0] name;
  } word_t;

  // One-hot 16-bit mask; slots at 16 and above have no bit
  function automatic logic [15:0] onehot16(input logic [4:0] idx);
    logic [15:0] m;
    m = idx[4] ? 16'h0000 : (16'h0001 << idx[3:0]);
    return m;
  endfunction

endpackage

// File: hdl/nta_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module nta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/neighbor_table_with_aging_core.sv
// Sequence: an input transfer starts the slot scan, one slot memory read per
//   cycle, then the drain and write-back states, then the result; in_stall
//   stays high until the result is loaded, so a new command waits for it.
// Reset: synchronous rst_n clears slot states, written flags and control at
//   once; max_silence returns to all ones. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Neighbor table with timeout aging
// Scans slot memory for name match, free slot, aging and read, then writes
// the chosen slot back for heard and set commands and returns one result per command.
// ----------------------------------------------------------------------------
`include "neighbor_table_with_aging_core_macros.svh"

module neighbor_table_with_aging_core #(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_neighbor_name,
  input  logic [31:0] in_time_now,
  input  logic [7:0]  in_bit_number,
  input  logic [4:0]  in_slot_index,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_slot_mask,
  output logic [1:0]  out_entry_state,
  output logic [7:0]  out_multicast_bit,
  output logic [31:0] out_name_out,
  output logic [15:0] out_live_mask,
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int WW = $bits(nta_pkg::word_t);
  localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  // Word seen for a slot that was never written
  nta_pkg::word_t reset_word;
  assign reset_word = '{bitn: 8'(NUM_SLOTS), contact: 32'h0, name: 32'h0};

  // --------------------------------------------------------------------------
  // Configuration register
  logic [31:0] max_silence_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'h0 : max_silence_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_silence_r <= 32'hFFFF_FFFF;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      max_silence_r <= cfg_pwdata;
    end
  end

  // --------------------------------------------------------------------------
  // Control and slot state
  logic [2:0]           fsm_r, fsm_nxt;
  logic [IW-1:0]        cnt_r, cnt_nxt;
  logic                 rd_vld_r;
  logic [IW-1:0]        rd_idx_r;
  logic [1:0]           state_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] wr_r;

  // Captured command
  logic [2:0]  cmd_r;
  logic [31:0] name_r;
  logic [31:0] now_r;
  logic [7:0]  bitn_r;
  logic [4:0]  idx_r;

  // Scan results
  logic           found_r, free_found_r;
  logic [IW-1:0]  hit_idx_r, free_idx_r;
  nta_pkg::word_t hit_word_r, free_word_r, rd_word_r;
  logic [1:0]     hit_state_r, rd_state_r;

  // Result awaiting the output register
  logic [2:0]  res_status_r, res_status_nxt;
  logic [15:0] res_mask_r, res_mask_nxt;
  logic [1:0]  res_state_r, res_state_nxt;
  logic [7:0]  res_mbit_r, res_mbit_nxt;
  logic [31:0] res_name_r, res_name_nxt;

  // Output register
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [15:0] out_mask_r;
  logic [1:0]  out_state_r;
  logic [7:0]  out_mbit_r;
  logic [31:0] out_name_r;
  logic [15:0] out_live_r;

  // Memory ports
  logic           ram_we;
  logic [IW-1:0]  ram_waddr;
  nta_pkg::word_t ram_wdata;
  logic           ram_re;
  logic [WW-1:0]  ram_q;

  logic           in_xfer;
  logic           out_load;
  nta_pkg::word_t scan_word;
  logic           scan_live;
  logic [31:0]    elapsed;
  logic           idx_ok;
  logic [15:0]    live_mask;

  assign in_stall = (fsm_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_load = (fsm_r == ST_OUT) && (!out_valid_r || !out_stall);

  // Slot under inspection this cycle
  assign scan_word = wr_r[rd_idx_r] ? nta_pkg::word_t'(ram_q) : reset_word;
  assign scan_live = (state_r[rd_idx_r] != nta_pkg::ENT_DISC);
  assign elapsed   = now_r - scan_word.contact;
  assign idx_ok    = (6'(idx_r) < 6'(NUM_SLOTS));

  // Live mask over the first sixteen slots
  for (genvar g = 0; g < 16; g++) begin : g_live
    if (g < NUM_SLOTS) begin : g_have
      assign live_mask[g] = (state_r[g] != nta_pkg::ENT_DISC);
    end else begin : g_none
      assign live_mask[g] = 1'b0;
    end
  end

  // Sequencer
  always_comb begin
    fsm_nxt = fsm_r;
    cnt_nxt = cnt_r;
    ram_re  = 1'b0;
    case (fsm_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_xfer) begin
          fsm_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ram_re = 1'b1;
        if (cnt_r == LAST) begin
          fsm_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN:  fsm_nxt = ST_DECIDE;
      ST_DECIDE: fsm_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          fsm_nxt = ST_IDLE;
        end
      end
      default: fsm_nxt = ST_IDLE;
    endcase
  end

  // Write-back of the chosen slot; the scan never reads while this writes
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_idx_r;
    ram_wdata = hit_word_r;
    if (fsm_r == ST_DECIDE) begin
      case (cmd_r)
        nta_pkg::CMD_HEARD: begin
          if (found_r) begin
            ram_we            = 1'b1;
            ram_wdata.contact = now_r;
          end else if (free_found_r) begin
            ram_we    = 1'b1;
            ram_waddr = free_idx_r;
            ram_wdata = '{bitn: free_word_r.bitn, contact: now_r, name: name_r};
          end
        end
        nta_pkg::CMD_SETBIT: begin
          if (found_r) begin
            ram_we         = 1'b1;
            ram_wdata.bitn = bitn_r;
          end
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  // Form the result from the scan
  always_comb begin
    res_status_nxt = nta_pkg::STS_DONE;
    res_mask_nxt   = 16'h0;
    res_state_nxt  = nta_pkg::ENT_DISC;
    res_mbit_nxt   = 8'h0;
    res_name_nxt   = 32'h0;
    case (cmd_r)
      nta_pkg::CMD_HEARD: begin
        if (found_r) begin
          res_mask_nxt  = nta_pkg::onehot16(5'(hit_idx_r));
          res_state_nxt = hit_state_r;
        end else if (free_found_r) begin
          res_status_nxt = nta_pkg::STS_ADDED;
          res_mask_nxt   = nta_pkg::onehot16(5'(free_idx_r));
          res_state_nxt  = nta_pkg::ENT_NOBIT;
        end else begin
          res_status_nxt = nta_pkg::STS_FULL;
        end
      end
      nta_pkg::CMD_SETBIT: begin
        if (found_r) begin
          res_mask_nxt  = nta_pkg::onehot16(5'(hit_idx_r));
          res_state_nxt = nta_pkg::ENT_CONN;
        end else begin
          res_status_nxt = nta_pkg::STS_NOTFOUND;
        end
      end
      nta_pkg::CMD_LOOKUP: begin
        if (found_r) begin
          res_mask_nxt  = nta_pkg::onehot16(5'(hit_idx_r));
          res_state_nxt = hit_state_r;
          if (hit_state_r == nta_pkg::ENT_CONN) begin
            res_mbit_nxt = hit_word_r.bitn;
          end
        end else begin
          res_status_nxt = nta_pkg::STS_NOTFOUND;
        end
      end
      nta_pkg::CMD_READ: begin
        if (idx_ok) begin
          res_state_nxt = rd_state_r;
          res_mbit_nxt  = rd_word_r.bitn;
          res_name_nxt  = rd_word_r.name;
        end else begin
          res_status_nxt = nta_pkg::STS_BADIDX;
        end
      end
      default: res_status_nxt = nta_pkg::STS_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= ST_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      wr_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        state_r[i] <= nta_pkg::ENT_DISC;
      end
    end else begin
      fsm_r    <= fsm_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= ram_re;

      // Age: drop live slots silent for too long
      if (rd_vld_r && (cmd_r == nta_pkg::CMD_AGE) && scan_live &&
          (elapsed > max_silence_r)) begin
        state_r[rd_idx_r] <= nta_pkg::ENT_DISC;
      end

      // Slot state and written flag updates at write-back
      if (fsm_r == ST_DECIDE) begin
        if (cmd_r == nta_pkg::CMD_HEARD && !found_r && free_found_r) begin
          state_r[free_idx_r] <= nta_pkg::ENT_NOBIT;
          wr_r[free_idx_r]    <= 1'b1;
        end
        if (cmd_r == nta_pkg::CMD_SETBIT && found_r) begin
          state_r[hit_idx_r] <= nta_pkg::ENT_CONN;
          wr_r[hit_idx_r]    <= 1'b1;
        end
      end

      // Output handshake
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture, scan and result payload
  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;

    if (in_xfer) begin
      cmd_r        <= in_cmd;
      name_r       <= in_neighbor_name;
      now_r        <= in_time_now;
      bitn_r       <= in_bit_number;
      idx_r        <= in_slot_index;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end

    // Track the first live match, the first free slot and the read slot
    if (rd_vld_r) begin
      if (scan_live && (scan_word.name == name_r) && !found_r) begin
        found_r     <= 1'b1;
        hit_idx_r   <= rd_idx_r;
        hit_word_r  <= scan_word;
        hit_state_r <= state_r[rd_idx_r];
      end
      if (!scan_live && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
        free_word_r  <= scan_word;
      end
      if (5'(rd_idx_r) == idx_r) begin
        rd_word_r  <= scan_word;
        rd_state_r <= state_r[rd_idx_r];
      end
    end

    // Hold the result at write-back
    if (fsm_r == ST_DECIDE) begin
      res_status_r <= res_status_nxt;
      res_mask_r   <= res_mask_nxt;
      res_state_r  <= res_state_nxt;
      res_mbit_r   <= res_mbit_nxt;
      res_name_r   <= res_name_nxt;
    end

    // Load the output register; live mask reflects the updated states
    if (out_load) begin
      out_status_r <= res_status_r;
      out_mask_r   <= res_mask_r;
      out_state_r  <= res_state_r;
      out_mbit_r   <= res_mbit_r;
      out_name_r   <= res_name_r;
      out_live_r   <= live_mask;
    end
  end

  nta_ram #(
    .WIDTH (WW),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt_r),
    .rdata (ram_q)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot_mask     = out_mask_r;
  assign out_entry_state   = out_state_r;
  assign out_multicast_bit = out_mbit_r;
  assign out_name_out      = out_name_r;
  assign out_live_mask     = out_live_r;

  // --------------------------------------------------------------------------
  // Assertions
  `NTA_ASSERT_SAME(a_write_only_decide, ram_we, fsm_r == ST_DECIDE, "slot write outside write-back")
  `NTA_ASSERT_SAME(a_read_only_scan, rd_vld_r, fsm_r == ST_SCAN || fsm_r == ST_DRAIN, "read data outside scan")
  `NTA_ASSERT_NEXT(a_decide_to_out, fsm_r == ST_DECIDE, fsm_r == ST_OUT, "write-back not followed by result")
  `NTA_ASSERT_NEXT(a_no_spurious_result, !out_valid_r && fsm_r != ST_OUT, !out_valid_r, "result without command")

endmodule

// File: test/neighbor_table_with_aging_core_tb.sv
// ----------------------------------------------------------------------------
// Neighbor table with aging testbench
// Sends heard, age, set, lookup and read commands with random input gaps and
// result stalls. A local copy of the slot table predicts every result, and
// each result is compared field by field, in order, across several silence
// limits.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int PHASE_ITEMS = 325;

  // Command codes the block treats as no operation
  localparam logic [2:0] CMD_SPARE5 = 3'd5;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  // Register byte addresses
  localparam logic [2:0] REG_MAX_SILENCE = 3'd0;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] name;
    logic [31:0] now;
    logic [7:0]  bitn;
    logic [4:0]  idx;
  } nbr_cmd_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] slot_mask;
    logic [1:0]  entry_state;
    logic [7:0]  mcast_bit;
    logic [31:0] name_out;
    logic [15:0] live_mask;
  } nbr_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_cmd = '0;
  logic [31:0] in_neighbor_name = '0;
  logic [31:0] in_time_now = '0;
  logic [7:0]  in_bit_number = '0;
  logic [4:0]  in_slot_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_slot_mask;
  logic [1:0]  out_entry_state;
  logic [7:0]  out_multicast_bit;
  logic [31:0] out_name_out;
  logic [15:0] out_live_mask;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predicted slot table and silence limit
  logic [31:0] tbl_name [SLOTS];
  logic [31:0] tbl_contact [SLOTS];
  logic [1:0]  tbl_state [SLOTS];
  logic [7:0]  tbl_bitn [SLOTS];
  logic [31:0] tbl_max_silence;

  nbr_cmd_t    cmd_backlog [$];
  nbr_result_t due_results [$];
  nbr_cmd_t    cur_cmd;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  logic        in_idling = 1'b1;
  logic        out_idling = 1'b1;
  int unsigned mismatches = 0;

  always #10 clk = ~clk;

  neighbor_table_with_aging_core #(
    .NUM_SLOTS(SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_neighbor_name(in_neighbor_name),
    .in_time_now(in_time_now),
    .in_bit_number(in_bit_number),
    .in_slot_index(in_slot_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_slot_mask(out_slot_mask),
    .out_entry_state(out_entry_state),
    .out_multicast_bit(out_multicast_bit),
    .out_name_out(out_name_out),
    .out_live_mask(out_live_mask),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  function automatic logic [15:0] slot_bit(input int k);
    return 16'd1 << k;
  endfunction

  // First live slot holding the name, lowest index wins
  function automatic int find_live_slot(input logic [31:0] nm);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_state[i] != nta_pkg::ENT_DISC && tbl_name[i] == nm) return i;
    end
    return -1;
  endfunction

  // Apply one command to the predicted table and return its result
  function automatic nbr_result_t apply_table_cmd(input nbr_cmd_t c);
    nbr_result_t r;
    int k;
    logic [31:0] silent;
    r = '{default: '0};
    case (c.cmd)
      nta_pkg::CMD_HEARD: begin
        k = find_live_slot(c.name);
        if (k >= 0) begin
          tbl_contact[k] = c.now;
          r.slot_mask = slot_bit(k);
          r.entry_state = tbl_state[k];
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (tbl_state[i] == nta_pkg::ENT_DISC) begin
              k = i;
              break;
            end
          end
          if (k >= 0) begin
            tbl_state[k] = nta_pkg::ENT_NOBIT;
            tbl_name[k] = c.name;
            tbl_contact[k] = c.now;
            r.status = nta_pkg::STS_ADDED;
            r.slot_mask = slot_bit(k);
            r.entry_state = nta_pkg::ENT_NOBIT;
          end else begin
            r.status = nta_pkg::STS_FULL;
          end
        end
      end
      nta_pkg::CMD_AGE: begin
        for (int i = 0; i < SLOTS; i++) begin
          silent = c.now - tbl_contact[i];
          if (tbl_state[i] != nta_pkg::ENT_DISC && silent > tbl_max_silence)
            tbl_state[i] = nta_pkg::ENT_DISC;
        end
      end
      nta_pkg::CMD_SETBIT: begin
        k = find_live_slot(c.name);
        if (k >= 0) begin
          tbl_bitn[k] = c.bitn;
          tbl_state[k] = nta_pkg::ENT_CONN;
          r.slot_mask = slot_bit(k);
          r.entry_state = nta_pkg::ENT_CONN;
        end else begin
          r.status = nta_pkg::STS_NOTFOUND;
        end
      end
      nta_pkg::CMD_LOOKUP: begin
        k = find_live_slot(c.name);
        if (k >= 0) begin
          r.slot_mask = slot_bit(k);
          r.entry_state = tbl_state[k];
          if (tbl_state[k] == nta_pkg::ENT_CONN) r.mcast_bit = tbl_bitn[k];
        end else begin
          r.status = nta_pkg::STS_NOTFOUND;
        end
      end
      nta_pkg::CMD_READ: begin
        if (c.idx < SLOTS) begin
          r.entry_state = tbl_state[c.idx];
          r.mcast_bit = tbl_bitn[c.idx];
          r.name_out = tbl_name[c.idx];
        end else begin
          r.status = nta_pkg::STS_BADIDX;
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_state[i] != nta_pkg::ENT_DISC) r.live_mask |= slot_bit(i);
    end
    return r;
  endfunction

  task automatic queue_cmd(input logic [2:0] c, input logic [31:0] nm, input logic [31:0] now,
                           input logic [7:0] b, input logic [4:0] ix);
    nbr_cmd_t item;
    item.cmd = c;
    item.name = nm;
    item.now = now;
    item.bitn = b;
    item.idx = ix;
    cmd_backlog.push_back(item);
  endtask

  // Write the silence limit through a setup and an access phase
  task automatic write_silence_limit(input logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_MAX_SILENCE;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    tbl_max_silence = v;
  endtask

  // Hold until every queued command is transferred and answered
  task automatic drain_table_cmds();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || due_results.size() != 0);
  endtask

  // Mostly a small set of recurring names on an advancing, wrapping clock
  task automatic queue_random_traffic(input int n);
    logic [31:0] pool [$];
    logic [31:0] clock_now;
    logic [31:0] nm;
    logic [31:0] stamp;
    logic [2:0]  op;
    int unsigned roll;
    clock_now = 32'hFFFF_FFFF - $urandom_range(0, 4000);
    repeat ($urandom_range(6, 28)) pool.push_back($urandom);
    pool.push_back(32'h0000_0000);
    pool.push_back(32'hFFFF_FFFF);
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 38) op = nta_pkg::CMD_HEARD;
      else if (roll < 52) op = nta_pkg::CMD_AGE;
      else if (roll < 66) op = nta_pkg::CMD_SETBIT;
      else if (roll < 80) op = nta_pkg::CMD_LOOKUP;
      else if (roll < 95) op = nta_pkg::CMD_READ;
      else op = 3'($urandom_range(CMD_SPARE5, CMD_SPARE7));
      clock_now += $urandom_range(0, 40);
      nm = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool.size() - 1)];
      stamp = ($urandom_range(0, 7) == 0) ? $urandom : clock_now;
      queue_cmd(op, nm, stamp, 8'($urandom), 5'($urandom_range(0, 31)));
    end
  endtask

  // Command driver: predict on each transfer, then load the next item after its gap
  always @(posedge clk) begin
    int unsigned wait_n;
    nbr_cmd_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      wait_n = gap_left;
      if (in_valid && !in_stall) begin
        due_results.push_back(apply_table_cmd(cur_cmd));
        if ($urandom_range(0, 39) == 0) in_idling <= !in_idling;
        wait_n = in_idling ? $urandom_range(0, 9) : 0;
      end
      if (!in_valid || !in_stall) begin
        if (wait_n == 0 && cmd_backlog.size() != 0) begin
          nxt = cmd_backlog.pop_front();
          cur_cmd <= nxt;
          in_valid <= 1'b1;
          in_cmd <= nxt.cmd;
          in_neighbor_name <= nxt.name;
          in_time_now <= nxt.now;
          in_bit_number <= nxt.bitn;
          in_slot_index <= nxt.idx;
          gap_left <= 0;
        end else begin
          in_valid <= 1'b0;
          gap_left <= (wait_n == 0) ? 0 : wait_n - 1;
        end
      end
    end
  end

  // Result monitor: check each transfer, then stall the next result a random while
  always @(posedge clk) begin
    nbr_result_t want;
    int unsigned n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result status=%0d mask=%h live=%h",
                   $realtime, out_status, out_slot_mask, out_live_mask);
      end else begin
        want = due_results.pop_front();
        if (out_status !== want.status || out_slot_mask !== want.slot_mask ||
            out_entry_state !== want.entry_state || out_multicast_bit !== want.mcast_bit ||
            out_name_out !== want.name_out || out_live_mask !== want.live_mask) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp sts=%0d msk=%h st=%0d mb=%0d nm=%h live=%h",
                     $realtime, want.status, want.slot_mask, want.entry_state,
                     want.mcast_bit, want.name_out, want.live_mask,
                     "\n            got sts=%0d msk=%h st=%0d mb=%0d nm=%h live=%h",
                     out_status, out_slot_mask, out_entry_state, out_multicast_bit,
                     out_name_out, out_live_mask);
        end
      end
      if ($urandom_range(0, 39) == 0) out_idling <= !out_idling;
      n = out_idling ? $urandom_range(0, 9) : 0;
      hold_left <= n;
      out_stall <= (n != 0);
    end else if (out_valid) begin
      if (hold_left <= 1) out_stall <= 1'b0;
      hold_left <= hold_left - 1;
    end
  end

  initial begin
    logic [31:0] silence_plan [6];
    silence_plan = '{32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd150, $urandom, 32'h8000_0000};
    tbl_max_silence = 32'hFFFF_FFFF;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_name[i] = '0;
      tbl_contact[i] = '0;
      tbl_state[i] = nta_pkg::ENT_DISC;
      tbl_bitn[i] = 8'(SLOTS);
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: index bounds, misses on an empty table, add, refresh, aging edge, full
    write_silence_limit(32'd100);
    queue_cmd(nta_pkg::CMD_READ, $urandom, $urandom, 8'($urandom), 5'd16);
    queue_cmd(nta_pkg::CMD_READ, $urandom, $urandom, 8'($urandom), 5'd31);
    queue_cmd(nta_pkg::CMD_LOOKUP, 32'h0000_0000, $urandom, 8'($urandom), 5'd0);
    queue_cmd(nta_pkg::CMD_SETBIT, 32'h0000_0000, $urandom, 8'h5A, 5'd0);
    queue_cmd(nta_pkg::CMD_HEARD, 32'h0000_0000, 32'hFFFF_FFF0, 8'h00, 5'd0);
    queue_cmd(nta_pkg::CMD_HEARD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 5'd31);
    queue_cmd(nta_pkg::CMD_HEARD, 32'h0000_0000, 32'd5, 8'h00, 5'd0);
    queue_cmd(nta_pkg::CMD_SETBIT, 32'hFFFF_FFFF, $urandom, 8'hFF, 5'd0);
    queue_cmd(nta_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, $urandom, 8'h00, 5'd0);
    // slot 0 sits exactly at the limit and stays, slot 1 is past it across the wrap and drops
    queue_cmd(nta_pkg::CMD_AGE, $urandom, 32'd105, 8'($urandom), 5'($urandom));
    queue_cmd(nta_pkg::CMD_READ, $urandom, $urandom, 8'($urandom), 5'd1);
    queue_cmd(CMD_SPARE7, $urandom, $urandom, 8'($urandom), 5'($urandom));
    repeat (15) queue_cmd(nta_pkg::CMD_HEARD, $urandom, 32'd110, 8'($urandom), 5'($urandom));
    queue_cmd(nta_pkg::CMD_HEARD, $urandom, 32'd111, 8'($urandom), 5'($urandom));
    queue_cmd(nta_pkg::CMD_LOOKUP, 32'h0000_0000, $urandom, 8'($urandom), 5'($urandom));
    queue_cmd(nta_pkg::CMD_READ, $urandom, $urandom, 8'($urandom), 5'd1);
    drain_table_cmds();

    // Random phases, one silence limit each
    for (int p = 0; p < 6; p++) begin
      write_silence_limit(silence_plan[p]);
      queue_random_traffic(PHASE_ITEMS);
      drain_table_cmds();
    end

    repeat (30) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
